// ===== rtl/olc_pkg.sv =====
package olc_pkg;

    // Default sizes of the list and of one entry.
    localparam int DEPTH_DEF      = 64;
    localparam int KEY_WIDTH_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the command and result items.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;

    // Command codes carried on s_tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_SEARCH    = 3'd2,
        CMD_NEXT      = 3'd3,
        CMD_READ      = 3'd4,
        CMD_RESET_CUR = 3'd5
    } olc_cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_EMPTY     = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_BAD_INDEX = 3'd4
    } olc_status_t;

    // Per-cycle controls broadcast to every cell.
    typedef struct packed {
        logic append;
        logic remove;
        logic use_hit;
    } olc_ctl_t;

    // Match flags rippling from the head cell to the tail cell.
    typedef struct packed {
        logic hit_seen;
        logic cur_behind;
        logic cur_on;
    } olc_flag_t;

endpackage

// ===== rtl/olc_cell.sv =====
module olc_cell #(
    parameter int IDX        = 0,
    parameter int DEPTH      = olc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH  = olc_pkg::KEY_WIDTH_DEF,
    parameter int DATA_WIDTH = olc_pkg::DATA_WIDTH_DEF,
    localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  olc_pkg::olc_ctl_t     ctl,
    input  logic                  cmp_en,
    input  logic [KEY_WIDTH-1:0]  cmp_key,
    input  logic [KEY_WIDTH-1:0]  wr_key,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [CW-1:0]         count,
    input  logic [IW-1:0]         rd_idx,
    input  logic [IW-1:0]         cur_idx,
    input  logic [KEY_WIDTH-1:0]  nxt_key,
    input  logic [DATA_WIDTH-1:0] nxt_data,
    input  olc_pkg::olc_flag_t    flg_in,
    output olc_pkg::olc_flag_t    flg_out,
    input  logic [KEY_WIDTH-1:0]  rd_key_in,
    output logic [KEY_WIDTH-1:0]  rd_key_out,
    input  logic [DATA_WIDTH-1:0] rd_data_in,
    output logic [DATA_WIDTH-1:0] rd_data_out,
    output logic [KEY_WIDTH-1:0]  key_q,
    output logic [DATA_WIDTH-1:0] data_q
);

    logic [KEY_WIDTH-1:0]  key_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic                  hit_reg;
    logic                  live;
    logic                  is_cur;
    logic                  first;
    logic                  sel;
    logic                  shift;

    assign key_q  = key_reg;
    assign data_q = data_reg;

    // Position of this cell relative to the fill level and the cursor.
    assign live   = (CW'(IDX) < count);
    assign is_cur = (IW'(IDX) == cur_idx);
    assign first  = hit_reg & ~flg_in.hit_seen;
    assign shift  = ctl.remove & (flg_in.hit_seen | hit_reg);

    // Match flags handed on to the next cell toward the tail.
    always_comb
    begin
        flg_out.hit_seen   = flg_in.hit_seen | hit_reg;
        flg_out.cur_behind = flg_in.cur_behind | (is_cur & flg_in.hit_seen);
        flg_out.cur_on     = flg_in.cur_on | (is_cur & first);
    end

    // Read bus: the selected cell ORs its entry onto the passing word.
    assign sel         = ctl.use_hit ? first : (IW'(IDX) == rd_idx);
    assign rd_key_out  = rd_key_in  | (sel ? key_reg  : '0);
    assign rd_data_out = rd_data_in | (sel ? data_reg : '0);

    // Key compare, taken when a request is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            hit_reg <= live && (key_reg == cmp_key);
        end
    end

    // Entry storage: written on append, shifted toward the head on removal.
    always_ff @(posedge clk)
    begin
        if (ctl.append && (CW'(IDX) == count))
        begin
            key_reg  <= wr_key;
            data_reg <= wr_data;
        end
        else if (shift)
        begin
            key_reg  <= nxt_key;
            data_reg <= nxt_data;
        end
    end

endmodule

// ===== rtl/ordered_list_with_cursor.sv =====
// Ordered list of up to DEPTH key/data entries with a read cursor.
// Requests arrive on the s_ channel: s_tuser carries the command (append,
// remove by key, search, cursor next, read at index, reset cursor) and
// s_tdata the key, the data word and the read index. Every request gives
// exactly one result on the m_ channel with a status, a found flag, the
// returned entry, the entry count and an empty flag.
// Each entry lives in one cell of a chain. Keys are compared in all cells
// in the cycle a request is accepted; in the update cycle the match flags
// ripple along the chain, a removal shifts the cells behind the match one
// step toward the head, and the count and cursor are updated.
// The result is registered at the end of the update cycle. A new request
// is accepted only after the previous one has left its update cycle, as
// s_tready is low from acceptance to the update. The result register frees
// s_tready while a result waits; if m_tready stays low, the next request is
// accepted but waits in its update cycle until the pending result is taken.
// Reset empties the list and leaves the cursor pointing nowhere; the cell
// contents are not cleared.
module ordered_list_with_cursor #(
    parameter int DEPTH      = olc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH  = olc_pkg::KEY_WIDTH_DEF,
    parameter int DATA_WIDTH = olc_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int IN_W      = KEY_WIDTH + DATA_WIDTH + olc_pkg::POS_W,
    localparam int IN_TW     = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = olc_pkg::STATUS_W + 1 + KEY_WIDTH + DATA_WIDTH + CW + 1,
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // Fields from bit 0 up: key, entry_data, position, zero fill.
    input  logic [IN_TW-1:0]            s_tdata,
    // Fields from bit 0 up: cmd.
    input  logic [olc_pkg::CMD_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // Fields from bit 0 up: status, found, key_out, data_out, entry_count,
    // is_empty, zero fill.
    output logic [OUT_TW-1:0]           m_tdata
);

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PCW = CW + olc_pkg::POS_W;

    typedef enum logic {
        ST_IDLE,
        ST_EXE
    } state_t;

    state_t                         state_reg;
    olc_pkg::olc_cmd_t              cmd_reg;
    logic [KEY_WIDTH-1:0]           key_reg;
    logic [DATA_WIDTH-1:0]          data_reg;
    logic [olc_pkg::POS_W-1:0]      pos_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [IW-1:0]                  cur_pos_reg;
    logic [IW-1:0]                  cur_pos_next;
    logic                           cur_null_reg;
    logic                           cur_null_next;
    logic                           m_tvalid_reg;
    logic [OUT_TW-1:0]              m_tdata_reg;

    logic                           in_acc;
    logic                           fire;
    logic [KEY_WIDTH-1:0]           s_key;
    olc_pkg::olc_ctl_t              ctl;
    logic [IW-1:0]                  rd_idx;
    logic [IW-1:0]                  next_p;
    logic [CW-1:0]                  next_p1;
    logic [CW-1:0]                  cnt_dec;
    olc_pkg::olc_status_t           res_status;
    logic                           res_found;
    logic                           res_take;
    logic [KEY_WIDTH-1:0]           res_key;
    logic [DATA_WIDTH-1:0]          res_data;

    olc_pkg::olc_flag_t             flg   [DEPTH+1];
    logic [KEY_WIDTH-1:0]           rk    [DEPTH+1];
    logic [DATA_WIDTH-1:0]          rdat  [DEPTH+1];
    logic [KEY_WIDTH-1:0]           ck    [DEPTH];
    logic [DATA_WIDTH-1:0]          cd    [DEPTH];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign fire     = (state_reg == ST_EXE) & (~m_tvalid_reg | m_tready);
    assign s_key    = s_tdata[KEY_WIDTH-1:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Controls broadcast to the cells in the update cycle.
    always_comb
    begin
        ctl.append  = fire && (cmd_reg == olc_pkg::CMD_APPEND) && (CW'(DEPTH) > count_reg);
        ctl.remove  = fire && (cmd_reg == olc_pkg::CMD_REMOVE);
        ctl.use_hit = (cmd_reg == olc_pkg::CMD_REMOVE) || (cmd_reg == olc_pkg::CMD_SEARCH);
    end

    // Entry the cursor-next command reads, and the place after it.
    assign next_p  = (cur_null_reg || (CW'(cur_pos_reg) >= count_reg)) ? '0 : cur_pos_reg;
    assign next_p1 = CW'(next_p) + CW'(1);
    assign cnt_dec = count_reg - CW'(1);
    assign rd_idx  = (cmd_reg == olc_pkg::CMD_READ) ? IW'(pos_reg) : next_p;

    // Chain of cells, head at index zero.
    assign flg[0]  = '0;
    assign rk[0]   = '0;
    assign rdat[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]  nk;
        logic [DATA_WIDTH-1:0] nd;

        if (i + 1 < DEPTH)
        begin : g_mid
            assign nk = ck[i+1];
            assign nd = cd[i+1];
        end
        else
        begin : g_tail
            assign nk = ck[i];
            assign nd = cd[i];
        end

        olc_cell #(
            .IDX        (i),
            .DEPTH      (DEPTH),
            .KEY_WIDTH  (KEY_WIDTH),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cmp_en      (in_acc),
            .cmp_key     (s_key),
            .wr_key      (key_reg),
            .wr_data     (data_reg),
            .count       (count_reg),
            .rd_idx      (rd_idx),
            .cur_idx     (cur_pos_reg),
            .nxt_key     (nk),
            .nxt_data    (nd),
            .flg_in      (flg[i]),
            .flg_out     (flg[i+1]),
            .rd_key_in   (rk[i]),
            .rd_key_out  (rk[i+1]),
            .rd_data_in  (rdat[i]),
            .rd_data_out (rdat[i+1]),
            .key_q       (ck[i]),
            .data_q      (cd[i])
        );
    end

    // Result and next count and cursor for the command in the update cycle.
    always_comb
    begin
        res_status    = olc_pkg::STS_OK;
        res_found     = 1'b0;
        res_take      = 1'b0;
        count_next    = count_reg;
        cur_pos_next  = cur_pos_reg;
        cur_null_next = cur_null_reg;
        case (cmd_reg)
            olc_pkg::CMD_APPEND:
            begin
                if (count_reg >= CW'(DEPTH))
                begin
                    res_status = olc_pkg::STS_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            olc_pkg::CMD_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    res_status = olc_pkg::STS_EMPTY;
                end
                else if (!flg[DEPTH].hit_seen)
                begin
                    res_status = olc_pkg::STS_NOT_FOUND;
                end
                else
                begin
                    res_found  = 1'b1;
                    res_take   = 1'b1;
                    count_next = cnt_dec;
                    if (!cur_null_reg)
                    begin
                        if (flg[DEPTH].cur_behind)
                        begin
                            cur_pos_next = cur_pos_reg - IW'(1);
                        end
                        else if (flg[DEPTH].cur_on && (CW'(cur_pos_reg) >= cnt_dec))
                        begin
                            cur_null_next = 1'b1;
                        end
                    end
                    if (cnt_dec == '0)
                    begin
                        cur_null_next = 1'b1;
                        cur_pos_next  = '0;
                    end
                end
            end
            olc_pkg::CMD_SEARCH:
            begin
                res_found = flg[DEPTH].hit_seen;
                res_take  = flg[DEPTH].hit_seen;
            end
            olc_pkg::CMD_NEXT:
            begin
                if (count_reg == '0)
                begin
                    res_status = olc_pkg::STS_EMPTY;
                end
                else
                begin
                    res_take = 1'b1;
                    if (next_p1 >= count_reg)
                    begin
                        cur_null_next = 1'b1;
                        cur_pos_next  = '0;
                    end
                    else
                    begin
                        cur_null_next = 1'b0;
                        cur_pos_next  = IW'(next_p1);
                    end
                end
            end
            olc_pkg::CMD_READ:
            begin
                if (count_reg == '0)
                begin
                    res_status = olc_pkg::STS_EMPTY;
                end
                else if (PCW'(pos_reg) >= PCW'(count_reg))
                begin
                    res_status = olc_pkg::STS_BAD_INDEX;
                end
                else
                begin
                    res_take      = 1'b1;
                    cur_pos_next  = IW'(pos_reg);
                    cur_null_next = 1'b0;
                end
            end
            olc_pkg::CMD_RESET_CUR:
            begin
                cur_pos_next  = '0;
                cur_null_next = (count_reg == '0);
            end
            default:
            begin
                res_status = olc_pkg::STS_OK;
            end
        endcase
        res_key  = res_take ? rk[DEPTH]   : '0;
        res_data = res_take ? rdat[DEPTH] : '0;
    end

    // Sequencer, list state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cur_pos_reg  <= '0;
            cur_null_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // A result is raised by an update and dropped once it is taken.
            if (fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= ST_EXE;
                    end
                end
                ST_EXE:
                begin
                    if (fire)
                    begin
                        state_reg    <= ST_IDLE;
                        count_reg    <= count_next;
                        cur_pos_reg  <= cur_pos_next;
                        cur_null_reg <= cur_null_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Request fields and result payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= olc_pkg::olc_cmd_t'(s_tuser);
            key_reg  <= s_key;
            data_reg <= s_tdata[KEY_WIDTH +: DATA_WIDTH];
            pos_reg  <= s_tdata[KEY_WIDTH + DATA_WIDTH +: olc_pkg::POS_W];
        end
        if (fire)
        begin
            m_tdata_reg <= OUT_TW'({(count_next == '0), count_next, res_data, res_key,
                                    res_found, res_status});
        end
    end

endmodule

// ===== rtl/olc_checker.sv =====
module olc_checker #(
    parameter int DEPTH      = olc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH  = olc_pkg::KEY_WIDTH_DEF,
    parameter int DATA_WIDTH = olc_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int OUT_W     = olc_pkg::STATUS_W + 1 + KEY_WIDTH + DATA_WIDTH + CW + 1,
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
    input logic              clk,
    input logic              rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_TW-1:0] m_tdata
);

    localparam int FND_B = olc_pkg::STATUS_W;
    localparam int KEY_L = FND_B + 1;
    localparam int CNT_L = KEY_L + KEY_WIDTH + DATA_WIDTH;
    localparam int EMP_B = CNT_L + CW;

    logic [olc_pkg::STATUS_W-1:0] status;
    logic                         found;
    logic [KEY_WIDTH-1:0]         key_out;
    logic [CW-1:0]                entry_count;
    logic                         is_empty;

    assign status      = m_tdata[olc_pkg::STATUS_W-1:0];
    assign found       = m_tdata[FND_B];
    assign key_out     = m_tdata[KEY_L +: KEY_WIDTH];
    assign entry_count = m_tdata[CNT_L +: CW];
    assign is_empty    = m_tdata[EMP_B];

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The count never exceeds the capacity.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> entry_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // The empty flag agrees with the count.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> is_empty == (entry_count == '0))
        else $error("empty flag disagrees with count");

    // A match is only reported with an ok status.
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && found |-> status == olc_pkg::STS_OK)
        else $error("match reported with an error status");

    // A failed command returns no entry.
    a_nokey: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status != olc_pkg::STS_OK) |-> key_out == '0 && !found)
        else $error("entry returned with an error status");

endmodule

bind ordered_list_with_cursor olc_checker #(
    .DEPTH      (DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_olc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/ordered_list_with_cursor_tb.sv =====
module ordered_list_with_cursor_tb;

    localparam int CMD_W         = olc_pkg::CMD_W;
    localparam int POS_W         = olc_pkg::POS_W;
    localparam int STATUS_W      = olc_pkg::STATUS_W;
    localparam int LIST_DEPTH    = 64;
    localparam int IN_TW         = 72;
    localparam int OUT_TW        = 80;
    localparam int TOTAL_ITEMS   = 1050;
    localparam int QUIET_TAIL    = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT     = 4_000_000;

    // Command codes the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_BROWSE} mix_t;

    // One expected answer of the list.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [31:0]         key_out;
        logic [31:0]         data_out;
        logic [6:0]          entry_count;
        logic                is_empty;
    } reply_t;

    // Shadow copy of the list; it predicts the answer to every accepted
    // request and checks the answers that come back in order.
    class list_mirror;
        logic [31:0] keys[LIST_DEPTH];
        logic [31:0] words[LIST_DEPTH];
        int unsigned count;
        int unsigned cur_pos;
        bit          cur_null;
        reply_t      pending_replies[$];
        int unsigned mismatches;
        int unsigned replies_seen;
        int unsigned full_hits;
        int unsigned empty_hits;

        function new();
            count = 0;
            cur_pos = 0;
            cur_null = 1'b1;
        endfunction

        function int find_first(logic [31:0] key);
            for (int i = 0; i < count; i++)
                if (keys[i] == key)
                    return i;
            return -1;
        endfunction

        function void apply_request(logic [CMD_W-1:0] cmd, logic [31:0] key,
                                    logic [31:0] word, logic [POS_W-1:0] pos);
            reply_t r;
            int hit;
            int i;
            r.status = olc_pkg::STS_OK;
            r.found = 1'b0;
            r.key_out = '0;
            r.data_out = '0;
            case (cmd)
                olc_pkg::CMD_APPEND:
                begin
                    if (count >= LIST_DEPTH)
                    begin
                        r.status = olc_pkg::STS_FULL;
                    end
                    else
                    begin
                        keys[count] = key;
                        words[count] = word;
                        count++;
                    end
                end
                olc_pkg::CMD_REMOVE:
                begin
                    hit = find_first(key);
                    if (count == 0)
                        r.status = olc_pkg::STS_EMPTY;
                    else if (hit < 0)
                        r.status = olc_pkg::STS_NOT_FOUND;
                    else
                    begin
                        r.found = 1'b1;
                        r.key_out = keys[hit];
                        r.data_out = words[hit];
                        // Close the gap toward the head.
                        for (i = hit; i + 1 < count; i++)
                        begin
                            keys[i] = keys[i + 1];
                            words[i] = words[i + 1];
                        end
                        count--;
                        // Keep the cursor on the same entry, or move it on.
                        if (!cur_null)
                        begin
                            if (cur_pos > hit)
                                cur_pos--;
                            else if (cur_pos == hit && cur_pos >= count)
                                cur_null = 1'b1;
                        end
                        if (count == 0)
                        begin
                            cur_null = 1'b1;
                            cur_pos = 0;
                        end
                    end
                end
                olc_pkg::CMD_SEARCH:
                begin
                    hit = find_first(key);
                    if (hit >= 0)
                    begin
                        r.found = 1'b1;
                        r.key_out = keys[hit];
                        r.data_out = words[hit];
                    end
                end
                olc_pkg::CMD_NEXT:
                begin
                    if (count == 0)
                    begin
                        r.status = olc_pkg::STS_EMPTY;
                    end
                    else
                    begin
                        // A cursor pointing nowhere wraps to the head.
                        if (cur_null || cur_pos >= count)
                        begin
                            cur_pos = 0;
                            cur_null = 1'b0;
                        end
                        r.key_out = keys[cur_pos];
                        r.data_out = words[cur_pos];
                        cur_pos++;
                        if (cur_pos >= count)
                        begin
                            cur_null = 1'b1;
                            cur_pos = 0;
                        end
                    end
                end
                olc_pkg::CMD_READ:
                begin
                    if (count == 0)
                        r.status = olc_pkg::STS_EMPTY;
                    else if (pos >= count)
                        r.status = olc_pkg::STS_BAD_INDEX;
                    else
                    begin
                        r.key_out = keys[pos];
                        r.data_out = words[pos];
                        cur_pos = 32'(pos);
                        cur_null = 1'b0;
                    end
                end
                olc_pkg::CMD_RESET_CUR:
                begin
                    cur_pos = 0;
                    cur_null = (count == 0);
                end
                default:
                begin
                end
            endcase
            if (r.status == olc_pkg::STS_FULL)
                full_hits++;
            if (r.status == olc_pkg::STS_EMPTY)
                empty_hits++;
            r.entry_count = 7'(count);
            r.is_empty = (count == 0);
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_TW-1:0] t);
            reply_t e;
            if (pending_replies.size() == 0)
            begin
                $error("result 0x%0h arrived with no request waiting", t);
                mismatches++;
                return;
            end
            e = pending_replies.pop_front();
            replies_seen++;
            compare_field("status", 32'(e.status), 32'(t[2:0]));
            compare_field("found", 32'(e.found), 32'(t[3]));
            compare_field("key_out", e.key_out, t[35:4]);
            compare_field("data_out", e.data_out, t[67:36]);
            compare_field("entry_count", 32'(e.entry_count), 32'(t[74:68]));
            compare_field("is_empty", 32'(e.is_empty), 32'(t[75]));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // Fields from bit 0 up: key, entry_data, position, zero fill.
    logic [IN_TW-1:0]  s_tdata;
    // Fields from bit 0 up: cmd.
    logic [CMD_W-1:0]  s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    // Fields from bit 0 up: status, found, key_out, data_out, entry_count,
    // is_empty, zero fill.
    logic [OUT_TW-1:0] m_tdata;

    list_mirror  mirror = new();
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          hold_req;
    int unsigned requests_sent;
    int unsigned spare_sent;
    int unsigned holds_done;

    ordered_list_with_cursor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 0;
    end

    always #10 clk = ~clk;

    // Offer one request, with an optional idle burst first, and wait until
    // it is accepted.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [31:0] key,
                                input logic [31:0] word, input logic [POS_W-1:0] pos);
        int gap;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, pos, word, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mirror.apply_request(cmd, key, word, pos);
        if (cmd == CMD_SPARE_6 || cmd == CMD_SPARE_7)
            spare_sent++;
        else
            requests_sent++;
    endtask

    // Keys mostly come from the list itself so removals and searches hit.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (mirror.count > 0 && sel < 6)
            return mirror.keys[$urandom_range(0, mirror.count - 1)];
        else if (sel < 8)
            return $urandom_range(0, 15);
        else if (sel == 8)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom;
    endfunction

    // Indexes mostly land in or just past the held entries.
    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 4) == 0 || mirror.count == 0)
            return POS_W'($urandom_range(0, 63));
        return POS_W'($urandom_range(0, (mirror.count < 64) ? mirror.count : 63));
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(mix_t mix);
        int r;
        int bound[6];
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   bound = '{55, 65, 75, 85, 95, 99};
            MIX_SHRINK: bound = '{15, 65, 75, 85, 95, 99};
            default:    bound = '{15, 30, 45, 75, 94, 99};
        endcase
        if (r < bound[0])
            return olc_pkg::CMD_APPEND;
        else if (r < bound[1])
            return olc_pkg::CMD_REMOVE;
        else if (r < bound[2])
            return olc_pkg::CMD_SEARCH;
        else if (r < bound[3])
            return olc_pkg::CMD_NEXT;
        else if (r < bound[4])
            return olc_pkg::CMD_READ;
        else if (r < bound[5])
            return olc_pkg::CMD_RESET_CUR;
        return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    endfunction

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int burst;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && holds_done == 0)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Check every result taken from the block.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
    end

    // Stimulus and end of run.
    initial
    begin
        mix_t mix;
        int   section_len;
        int   pick;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        rst_n    = 1'b0;
        hold_req = 1'b0;
        gap_pct  = 20;
        stall_pct = 20;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: commands on an empty list first.
        send_request(olc_pkg::CMD_NEXT, 32'h0, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_REMOVE, 32'h5, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_READ, 32'h0, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_SEARCH, 32'h0, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_RESET_CUR, 32'h0, 32'h0, 6'd0);
        // Extreme keys and words, and a duplicate key.
        send_request(olc_pkg::CMD_APPEND, 32'h0, 32'h0, 6'd63);
        send_request(olc_pkg::CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        send_request(olc_pkg::CMD_APPEND, 32'h1234_5678, 32'h0000_2710, 6'd0);
        send_request(olc_pkg::CMD_APPEND, 32'hFFFF_FFFF, 32'h0000_0001, 6'd0);
        send_request(olc_pkg::CMD_APPEND, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 6'd0);
        // The last entry must be found, and the first of two duplicates.
        send_request(olc_pkg::CMD_SEARCH, 32'hA5A5_A5A5, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_SEARCH, 32'h0BAD_F00D, 32'h0, 6'd0);
        // Bad indexes, then the last entry and a wrap of the cursor.
        send_request(olc_pkg::CMD_READ, 32'h0, 32'h0, 6'd63);
        send_request(olc_pkg::CMD_READ, 32'h0, 32'h0, 6'd5);
        send_request(olc_pkg::CMD_READ, 32'h0, 32'h0, 6'd4);
        send_request(olc_pkg::CMD_NEXT, 32'h0, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_NEXT, 32'h0, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_REMOVE, 32'h0BAD_F00D, 32'h0, 6'd0);
        // Removal with the cursor on the removed entry, then behind it.
        send_request(olc_pkg::CMD_READ, 32'h0, 32'h0, 6'd2);
        send_request(olc_pkg::CMD_REMOVE, 32'h1234_5678, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_NEXT, 32'h0, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 6'd0);
        send_request(olc_pkg::CMD_NEXT, 32'h0, 32'h0, 6'd0);
        send_request(CMD_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_request(CMD_SPARE_7, 32'h0, 32'h0, 6'd0);

        // Fill the list to the top and push two more appends against it.
        while (mirror.count < LIST_DEPTH)
            send_request(olc_pkg::CMD_APPEND, pick_key(), $urandom, pick_pos());
        send_request(olc_pkg::CMD_APPEND, $urandom, $urandom, pick_pos());
        send_request(olc_pkg::CMD_APPEND, pick_key(), $urandom, pick_pos());

        // Random sections with a command mix that follows the fill level.
        while (requests_sent < TOTAL_ITEMS)
        begin
            if (mirror.count >= 56)
                mix = MIX_SHRINK;
            else if (mirror.count < 8)
                mix = MIX_GROW;
            else
                mix = mix_t'($urandom_range(0, 2));
            section_len = $urandom_range(20, 60);
            if (requests_sent + QUIET_TAIL >= TOTAL_ITEMS)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                pick = $urandom_range(0, 3);
                gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
                pick = $urandom_range(0, 3);
                stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
            end
            // Once, halfway through, the receiver holds off while requests keep coming.
            if (holds_done == 0 && !hold_req && requests_sent >= TOTAL_ITEMS / 2)
            begin
                hold_req <= 1'b1;
                gap_pct = 0;
            end
            repeat (section_len)
            begin
                if (requests_sent < TOTAL_ITEMS)
                    send_request(pick_cmd(mix), pick_key(), $urandom, pick_pos());
            end
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then let the block settle.
        while (mirror.pending_replies.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d list commands and %0d unused codes; %0d results checked.",
                 requests_sent, spare_sent, mirror.replies_seen);
        $display("The list was hit full %0d times and empty %0d times; %0d long hold-off.",
                 mirror.full_hits, mirror.empty_hits, holds_done);
        if (mirror.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout with %0d results outstanding.", mirror.pending_replies.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== ordered_list_with_cursor.f =====
rtl/olc_pkg.sv
rtl/olc_cell.sv
rtl/ordered_list_with_cursor.sv
rtl/olc_checker.sv
tb/sv/ordered_list_with_cursor_tb.sv
